>>> src/mt19937_word_generator_top_defines.svh
// ----------------------------------------------------------------------------
// MT19937 word generator assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MT19937_WORD_GENERATOR_TOP_DEFINES_SVH
`define MT19937_WORD_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MTWG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define MTWG_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTWG_ASSERT(name, clk, rst_n, prop, msg)
`define MTWG_ASSERT_NORST(name, clk, prop, msg)
`endif

`endif

>>> src/mtwg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 word generator package
// Constants, controller/datapath interface types and word functions.
// ----------------------------------------------------------------------------
package mtwg_pkg;

  localparam int unsigned N_WORDS  = 624;
  localparam int unsigned M_OFFSET = 397;
  localparam int unsigned IDX_W    = 10;

  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(N_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_TWIST    = IDX_W'(N_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(N_WORDS + 1);

  localparam logic [31:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [32:0] VALUE_SAT    = 33'h0_ffff_ffff;

  localparam logic CMD_RAW    = 1'b0;
  localparam logic CMD_RANGED = 1'b1;

  localparam logic REG_SEED = 1'b0;

  typedef struct packed {
    logic cap_item;
    logic fill_first;
    logic fill_mul;
    logic fill_wr;
    logic tw_prime;
    logic tw_load;
    logic tw_rd;
    logic tw_wr;
    logic word_rd;
    logic temper;
    logic mod_start;
    logic out_load;
  } mtwg_cmd_t;

  typedef struct packed {
    logic idx_seed;
    logic idx_twist;
    logic cnt_last;
    logic ranged;
    logic span_zero;
    logic mod_last;
    logic out_free;
  } mtwg_sts_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] mt_mix(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] far);
    logic [31:0] y;
    y = (a & UPPER_MASK) | (b & LOWER_MASK);
    return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'h0);
  endfunction

  function automatic logic [31:0] mt_fill_mul(input logic [31:0] p);
    logic [31:0] x;
    x = p ^ (p >> 30);
    return INIT_MULT * x;
  endfunction

endpackage

>>> src/mtwg_mod.sv
// ----------------------------------------------------------------------------
// MT19937 remainder unit
// Restoring 32-bit remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "mt19937_word_generator_top_defines.svh"

module mtwg_mod import mtwg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        last_o,
  output logic [31:0] rem_o
);

  localparam int unsigned ITER  = 32;
  localparam int unsigned CNT_W = $clog2(ITER);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q;
  logic [31:0]      dvd_q;
  logic [31:0]      dsr_q;
  logic [32:0]      trial;
  logic [32:0]      diff;

  assign trial  = {rem_q, dvd_q[31]};
  assign diff   = trial - {1'b0, dsr_q};
  assign last_o = busy_q && (cnt_q == CNT_W'(ITER - 1));
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[32] ? trial[31:0] : diff[31:0];
      dvd_q <= dvd_q << 1;
    end
  end

  `MTWG_ASSERT(a_start_when_free, clk_i, rst_ni, start_i |-> !busy_q, "remainder unit restarted while busy")
  `MTWG_ASSERT(a_rem_below_divisor, clk_i, rst_ni, last_o |=> (rem_q < dsr_q), "remainder not below divisor")

endmodule

>>> src/mtwg_ctrl.sv
// ----------------------------------------------------------------------------
// MT19937 controller
// Sequences state fill, twist, word read, reduction and result hand-off.
// ----------------------------------------------------------------------------
module mtwg_ctrl import mtwg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mtwg_sts_t sts_i,
  output mtwg_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_FILL0    = 12'b0000_0000_0010,
    ST_FILL_MUL = 12'b0000_0000_0100,
    ST_FILL_WR  = 12'b0000_0000_1000,
    ST_TW_PRIME = 12'b0000_0001_0000,
    ST_TW_LOAD  = 12'b0000_0010_0000,
    ST_TW_RD    = 12'b0000_0100_0000,
    ST_TW_WR    = 12'b0000_1000_0000,
    ST_READ     = 12'b0001_0000_0000,
    ST_TEMPER   = 12'b0010_0000_0000,
    ST_DIVIDE   = 12'b0100_0000_0000,
    ST_FINISH   = 12'b1000_0000_0000
  } mtwg_state_e;

  mtwg_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          if (sts_i.idx_seed) begin
            state_d = ST_FILL0;
          end else if (sts_i.idx_twist) begin
            state_d = ST_TW_PRIME;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_FILL0: begin
        cmd_o.fill_first = 1'b1;
        state_d = ST_FILL_MUL;
      end
      ST_FILL_MUL: begin
        cmd_o.fill_mul = 1'b1;
        state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d = sts_i.cnt_last ? ST_TW_PRIME : ST_FILL_MUL;
      end
      ST_TW_PRIME: begin
        cmd_o.tw_prime = 1'b1;
        state_d = ST_TW_LOAD;
      end
      ST_TW_LOAD: begin
        cmd_o.tw_load = 1'b1;
        state_d = ST_TW_RD;
      end
      ST_TW_RD: begin
        cmd_o.tw_rd = 1'b1;
        state_d = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd_o.tw_wr = 1'b1;
        state_d = sts_i.cnt_last ? ST_READ : ST_TW_RD;
      end
      ST_READ: begin
        cmd_o.word_rd = 1'b1;
        state_d = ST_TEMPER;
      end
      ST_TEMPER: begin
        cmd_o.temper = 1'b1;
        if (sts_i.ranged && !sts_i.span_zero) begin
          cmd_o.mod_start = 1'b1;
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (sts_i.mod_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/mtwg_dp.sv
// ----------------------------------------------------------------------------
// MT19937 datapath
// State memory, seed fill, twist, tempering, range reduction, result register.
// ----------------------------------------------------------------------------
`include "mt19937_word_generator_top_defines.svh"

module mtwg_dp import mtwg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtwg_cmd_t          cmd_i,
  output mtwg_sts_t          sts_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic [31:0]        seed_o,
  input  logic               command_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [32:0] value_o,
  output logic               range_empty_o
);

  logic [31:0] twister_mem_q [N_WORDS];
  logic [31:0] rd_a_q, rd_b_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [31:0]      mem_wdata;

  logic [31:0]      seed_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] cnt_q;
  logic             out_valid_q;

  logic [31:0] prev_q, prod_q, cur_q, word_q;
  logic        cmd_q;
  logic [31:0] lo_q;
  logic [32:0] diff_q;
  logic [32:0] value_q;
  logic        empty_q;

  logic [31:0]      fill_val;
  logic [31:0]      tempered;
  logic [IDX_W-1:0] next_idx, far_idx;
  logic [IDX_W:0]   far_sum;
  logic [32:0]      diff_neg;
  logic [31:0]      span;
  logic             span_zero;
  logic             mod_last;
  logic [31:0]      mod_rem;
  logic [33:0]      sum;
  logic [32:0]      ranged_val;
  logic [32:0]      value_d;
  logic             empty_d;

  assign fill_val = prod_q + {{(32 - IDX_W){1'b0}}, cnt_q};
  assign tempered = mt_temper(rd_a_q);
  assign next_idx = (cnt_q == IDX_LAST) ? '0 : cnt_q + 1'b1;
  assign far_sum  = {1'b0, cnt_q} + (IDX_W + 1)'(M_OFFSET);
  assign far_idx  = (far_sum >= (IDX_W + 1)'(N_WORDS)) ?
                    IDX_W'(far_sum - (IDX_W + 1)'(N_WORDS)) : far_sum[IDX_W-1:0];

  assign diff_neg  = '0 - diff_q;
  assign span      = diff_q[32] ? diff_neg[31:0] : diff_q[31:0];
  assign span_zero = (diff_q == '0);

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = fill_val;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    if (cmd_i.fill_first) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = seed_q;
    end
    if (cmd_i.fill_wr) begin
      mem_we = 1'b1;
    end
    if (cmd_i.tw_wr) begin
      mem_we    = 1'b1;
      mem_wdata = mt_mix(cur_q, rd_a_q, rd_b_q);
    end
    if (cmd_i.tw_rd) begin
      mem_raddr_a = next_idx;
      mem_raddr_b = far_idx;
    end
    if (cmd_i.word_rd) begin
      mem_raddr_a = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      twister_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= twister_mem_q[mem_raddr_a];
    rd_b_q <= twister_mem_q[mem_raddr_b];
  end

  mtwg_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (tempered),
    .divisor_i  (span),
    .last_o     (mod_last),
    .rem_o      (mod_rem)
  );

  assign sum        = {2'b00, mod_rem} + {{2{lo_q[31]}}, lo_q};
  assign ranged_val = (!sum[33] && sum[32]) ? VALUE_SAT : sum[32:0];

  always_comb begin
    if (cmd_q == CMD_RANGED) begin
      value_d = span_zero ? {lo_q[31], lo_q} : ranged_val;
      empty_d = span_zero;
    end else begin
      value_d = {1'b0, word_q};
      empty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= DEFAULT_SEED;
      idx_q       <= IDX_UNSEEDED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
        idx_q  <= IDX_UNSEEDED;
      end else if (cmd_i.tw_wr && (cnt_q == IDX_LAST)) begin
        idx_q <= '0;
      end else if (cmd_i.word_rd) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fill_first) begin
        cnt_q <= IDX_W'(1);
      end else if (cmd_i.fill_wr || cmd_i.tw_wr) begin
        cnt_q <= next_idx;
      end else if (cmd_i.tw_prime) begin
        cnt_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      cmd_q  <= command_i;
      lo_q   <= range_low_i;
      diff_q <= {range_high_i[31], range_high_i} - {range_low_i[31], range_low_i};
    end
    if (cmd_i.fill_first) begin
      prev_q <= seed_q;
    end else if (cmd_i.fill_wr) begin
      prev_q <= fill_val;
    end
    if (cmd_i.fill_mul) begin
      prod_q <= mt_fill_mul(prev_q);
    end
    if (cmd_i.tw_load || cmd_i.tw_wr) begin
      cur_q <= rd_a_q;
    end
    if (cmd_i.temper) begin
      word_q <= tempered;
    end
    if (cmd_i.out_load) begin
      value_q <= value_d;
      empty_q <= empty_d;
    end
  end

  assign sts_o.idx_seed  = (idx_q > IDX_TWIST);
  assign sts_o.idx_twist = (idx_q == IDX_TWIST);
  assign sts_o.cnt_last  = (cnt_q == IDX_LAST);
  assign sts_o.ranged    = (cmd_q == CMD_RANGED);
  assign sts_o.span_zero = span_zero;
  assign sts_o.mod_last  = mod_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign seed_o        = seed_q;
  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign range_empty_o = empty_q;

  `MTWG_ASSERT(a_word_rd_in_range, clk_i, rst_ni, cmd_i.word_rd |-> (idx_q < IDX_TWIST), "word read from unprepared state")
  `MTWG_ASSERT(a_mod_nonzero_span, clk_i, rst_ni, cmd_i.mod_start |-> !span_zero, "remainder started with zero span")
  `MTWG_ASSERT(a_no_result_overwrite, clk_i, rst_ni, cmd_i.out_load |-> (!out_valid_q || out_ready_i), "pending result overwritten")

endmodule

>>> src/mt19937_word_generator_top.sv
// ----------------------------------------------------------------------------
// MT19937 word generator: a raw beat reads and tempers one state word; a ranged beat
// also runs the remainder unit. A new request is accepted only after the previous result
// is loaded into the result register. First draw after reset or seed write adds a state
// fill; every 624th word adds a twist. Async active-low reset: seed 5489, state unseeded.
// ----------------------------------------------------------------------------
module mt19937_word_generator_top import mtwg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [32:0] value_o,
  output logic               range_empty_o
);

  mtwg_cmd_t   cmd;
  mtwg_sts_t   sts;
  logic        cfg_we;
  logic [31:0] seed;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SEED);
  assign prdata = (paddr[2] == REG_SEED) ? seed : 32'h0;

  mtwg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtwg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata),
    .seed_o        (seed),
    .command_i     (command_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .value_o       (value_o),
    .range_empty_o (range_empty_o)
  );

endmodule
